/* sv/soa_pkg.sv */
// package for the slab object allocator: word types, status codes, constants
// no dependencies
package soa_pkg;

  localparam int unsigned PageBytesDef   = 4096;
  localparam int unsigned HeaderBytesDef = 32;
  localparam int unsigned MaxSlabsDef    = 16;
  localparam int unsigned MaxSlotsDef    = 1024;

  localparam logic [0:0] ReqAlloc = 1'b0;
  localparam logic [0:0] ReqFree  = 1'b1;

  localparam logic [2:0] StatOk        = 3'd0;
  localparam logic [2:0] StatExhausted = 3'd1;
  localparam logic [2:0] StatTooLarge  = 3'd2;
  localparam logic [2:0] StatNotFound  = 3'd3;
  localparam logic [2:0] StatMisalign  = 3'd4;

  localparam logic [1:0] CfgHeapBase  = 2'd0;
  localparam logic [1:0] CfgPageLimit = 2'd1;
  localparam logic [1:0] CfgObjLog2   = 2'd2;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [31:0] free_addr;
  } req_word_t;

  typedef struct packed {
    logic [31:0] obj_addr;
    logic [2:0]  status;
  } rsp_word_t;

endpackage

/* sv/soa_link_ram.sv */
// free-list link memory, one write and one registered read port
// depends on soa_pkg
module soa_link_ram import soa_pkg::*; #(
  parameter int unsigned Depth = MaxSlabsDef * MaxSlotsDef,
  parameter int unsigned Width = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/slab_object_allocator_core.sv */
// slab object allocator top level: config registers, sequencer, slab tables
// depends on soa_pkg and soa_link_ram
//
// One request at a time: start is taken while busy is low, and exactly one
// result word appears on rsp_o with done_o high for one cycle; the receiver
// cannot stall it. An allocate walks the slabs newest first, one slab per
// cycle; when a new slab must be built, its link list is written one slot
// per cycle, up to the slab capacity (at most MaxSlots slots). A free walks
// the slabs one per cycle with a single shared subtract and compare unit.
// The link memory has one write and one read port, which sets the
// slot-linking time. Configuration writes are taken at any time but should
// come only while busy is low.
module slab_object_allocator_core import soa_pkg::*; #(
  parameter int unsigned PageBytes   = PageBytesDef,
  parameter int unsigned HeaderBytes = HeaderBytesDef,
  parameter int unsigned MaxSlabs    = MaxSlabsDef,
  parameter int unsigned MaxSlots    = MaxSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  req_word_t   req_i,
  output logic        busy,
  output logic        done_o,
  output rsp_word_t   rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned SW  = $clog2(MaxSlots + 1);       // slot value incl. nil
  localparam int unsigned SIW = $clog2(MaxSlots);           // slot index
  localparam int unsigned KW  = (MaxSlabs > 1) ? $clog2(MaxSlabs) : 1;
  localparam int unsigned CW  = $clog2(MaxSlabs + 1);       // slab count
  localparam int unsigned PL  = $clog2(PageBytes);
  localparam int unsigned AW  = $clog2(MaxSlabs * MaxSlots);
  localparam logic [SW-1:0] NilSlot = SW'(MaxSlots);

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StLink  = 3'd2;
  localparam logic [2:0] StPop   = 3'd3;
  localparam logic [2:0] StPop2  = 3'd4;
  localparam logic [2:0] StFree  = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  // config registers
  logic [31:0] heap_base_q;
  logic [4:0]  page_limit_q;
  logic [3:0]  obj_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      page_limit_q <= 5'd16;
      obj_log2_q   <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeapBase:  heap_base_q  <= cfg_data_i;
        CfgPageLimit: page_limit_q <= cfg_data_i[4:0];
        CfgObjLog2:   obj_log2_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // derived geometry, recomputed only from config registers
  logic [16:0] obj_bytes;
  logic [17:0] area_off;
  logic [SW-1:0] cap;
  logic [31:0] page0;
  logic [CW-1:0] limit;
  logic [17:0] cap_raw;

  always_comb begin
    obj_bytes = 17'd1 << obj_log2_q;
    // header rounded up to the object size
    area_off  = ((18'(HeaderBytes) + 18'(obj_bytes) - 18'd1) >> obj_log2_q) << obj_log2_q;
    if (area_off >= 18'(PageBytes)) begin
      cap_raw = '0;
    end else begin
      cap_raw = (18'(PageBytes) - area_off) >> obj_log2_q;
    end
    cap   = (cap_raw > 18'(MaxSlots)) ? NilSlot : SW'(cap_raw);
    page0 = {heap_base_q[31:PL], {PL{1'b0}}};
    limit = (32'(page_limit_q) < MaxSlabs) ? CW'(page_limit_q) : CW'(MaxSlabs);
  end

  // slab tables, read at one slab a cycle
  logic [SW-1:0] used_q [MaxSlabs];
  logic [SW-1:0] head_q [MaxSlabs];
  logic [CW-1:0] made_q;

  logic [2:0]  st_q;
  logic [CW-1:0] it_q;          // scan index, counts down
  logic [KW-1:0] k_q;
  logic [SW-1:0] li_q;          // link fill counter
  logic          is_free_q;
  logic [31:0]   addr_q;
  rsp_word_t     rsp_q;
  logic          done_q;

  logic [KW-1:0] kk;
  logic [31:0]   start_addr, off;
  logic [31:0]   range;
  assign kk = KW'(it_q - CW'(1));
  // shared unit: slab start and offset from the freed address
  assign start_addr = page0 + (32'(kk) << PL) + 32'(area_off);
  assign off        = addr_q - start_addr;
  assign range      = 32'(cap) << obj_log2_q;

  // link memory
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [SW-1:0] ram_wd, ram_rd;

  soa_link_ram #(.Depth(MaxSlabs * MaxSlots), .Width(SW)) u_link (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .raddr_i (ram_ra),
    .rdata_o (ram_rd)
  );

  logic [SIW-1:0] free_slot;
  logic [31:0]    off_sh;
  assign off_sh    = off >> obj_log2_q;
  assign free_slot = off_sh[SIW-1:0];

  always_comb begin
    ram_we = 1'b0;
    ram_wa = {k_q, li_q[SIW-1:0]};
    ram_wd = (li_q + SW'(1) < cap) ? li_q + SW'(1) : NilSlot;
    ram_ra = {k_q, head_q[k_q][SIW-1:0]};
    if (st_q == StLink) begin
      ram_we = 1'b1;
    end else if (st_q == StFree && it_q != '0 && off < range &&
                 (off & (32'(obj_bytes) - 32'd1)) == '0 && used_q[kk] != '0) begin
      ram_we = 1'b1;
      ram_wa = {kk, free_slot};
      ram_wd = head_q[kk];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      made_q    <= '0;
      done_q    <= 1'b0;
      it_q      <= '0;
      k_q       <= '0;
      li_q      <= '0;
      is_free_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          // the result cycle still counts as busy
          if (start && !busy) begin
            addr_q    <= req_i.free_addr;
            is_free_q <= (req_i.req_type == ReqFree);
            it_q      <= made_q;
            st_q      <= (req_i.req_type == ReqFree) ? StFree : StScan;
          end
        end
        StScan: begin
          if (it_q == '0) begin
            if (made_q >= limit) begin
              rsp_q <= '{obj_addr: '0, status: StatExhausted};
              st_q  <= StDone;
            end else if (cap == '0) begin
              rsp_q <= '{obj_addr: '0, status: StatTooLarge};
              st_q  <= StDone;
            end else begin
              k_q  <= KW'(made_q);
              li_q <= '0;
              st_q <= StLink;
            end
          end else if (used_q[kk] < cap && head_q[kk] < cap) begin
            k_q  <= kk;
            st_q <= StPop;
          end else begin
            it_q <= it_q - CW'(1);
          end
        end
        StLink: begin
          if (li_q + SW'(1) >= cap) begin
            head_q[k_q] <= '0;
            used_q[k_q] <= '0;
            made_q      <= made_q + CW'(1);
            st_q        <= StPop;
          end else begin
            li_q <= li_q + SW'(1);
          end
        end
        StPop: begin
          st_q <= StPop2;   // registered link read
        end
        StPop2: begin
          head_q[k_q] <= ram_rd;
          used_q[k_q] <= used_q[k_q] + SW'(1);
          rsp_q <= '{obj_addr: page0 + (32'(k_q) << PL) + 32'(area_off)
                               + (32'(head_q[k_q]) << obj_log2_q),
                     status: StatOk};
          st_q <= StDone;
        end
        StFree: begin
          if (it_q == '0) begin
            rsp_q <= '{obj_addr: '0, status: StatNotFound};
            st_q  <= StDone;
          end else if (off < range) begin
            if ((off & (32'(obj_bytes) - 32'd1)) != '0) begin
              rsp_q <= '{obj_addr: '0, status: StatMisalign};
            end else begin
              rsp_q <= '{obj_addr: '0, status: StatOk};
              if (used_q[kk] != '0) begin
                head_q[kk] <= SW'(free_slot);
                used_q[kk] <= used_q[kk] - SW'(1);
              end
            end
            st_q <= StDone;
          end else begin
            it_q <= it_q - CW'(1);
          end
        end
        StDone: begin
          done_q <= 1'b1;
          st_q   <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign busy   = (st_q != StIdle) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result word held over");
  a_made_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    made_q <= CW'(MaxSlabs)) else $error("slab count overflow");
  a_free_nolink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StLink) |-> !is_free_q) else $error("link fill on free");
endmodule
